// ===== hdl/irdl_pkg.sv =====
package irdl_pkg;

  // Table size and field widths.
  localparam int TABLE_POINTS = 13;
  localparam int SAMPLE_W     = 9;
  localparam int DIST_W       = 10;
  localparam int CODE_W       = 2;
  localparam int DEN_W        = 9;
  localparam int RISE_W       = 10;
  localparam int NUM_W        = DEN_W + RISE_W;
  localparam int Q_W          = NUM_W;
  localparam int RECIP_SHIFT  = NUM_W;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int PROD_W       = NUM_W + RECIP_W;
  localparam int QD_W         = Q_W + DEN_W;
  localparam int SUM_W        = Q_W + 1;
  localparam int SEGS         = TABLE_POINTS - 1;
  localparam int SEG_W        = (SEGS > 1) ? $clog2(SEGS) : 1;

  // Falling voltage points and rising distance points.
  localparam logic [SAMPLE_W-1:0] VOLT_PTS [TABLE_POINTS] = '{
    9'd315, 9'd295, 9'd273, 9'd231, 9'd164, 9'd131, 9'd108,
    9'd92, 9'd74, 9'd61, 9'd52, 9'd45, 9'd40
  };
  localparam logic [DIST_W-1:0] DIST_PTS [TABLE_POINTS] = '{
    10'd60, 10'd70, 10'd80, 10'd100, 10'd150, 10'd200, 10'd250,
    10'd300, 10'd400, 10'd500, 10'd600, 10'd700, 10'd800
  };

  // Per-segment voltage span, distance rise and floor(2^RECIP_SHIFT / span).
  localparam logic [DEN_W-1:0] SEG_DEN [SEGS] = '{
    9'd20, 9'd22, 9'd42, 9'd67, 9'd33, 9'd23, 9'd16, 9'd18, 9'd13, 9'd9, 9'd7, 9'd5
  };
  localparam logic [RISE_W-1:0] SEG_RISE [SEGS] = '{
    10'd10, 10'd10, 10'd20, 10'd50, 10'd50, 10'd50, 10'd50,
    10'd100, 10'd100, 10'd100, 10'd100, 10'd100
  };
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEGS] = '{
    20'd26214, 20'd23831, 20'd12483, 20'd7825, 20'd15887, 20'd22795,
    20'd32768, 20'd29127, 20'd40329, 20'd58254, 20'd74898, 20'd104857
  };

  typedef enum logic [CODE_W-1:0] {
    RANGE_IN   = 2'd0,
    RANGE_NEAR = 2'd1,
    RANGE_FAR  = 2'd2
  } range_code_t;

  // What the segment lookup hands to the arithmetic stages.
  typedef struct packed {
    logic [DIST_W-1:0]   base;
    logic [SAMPLE_W-1:0] delta;
    logic [SEG_W-1:0]    seg;
    range_code_t         code;
  } seg_info_t;

endpackage

// ===== hdl/irdl_seg_lookup.sv =====
module irdl_seg_lookup (
  input  logic [irdl_pkg::SAMPLE_W-1:0] sample,
  output irdl_pkg::seg_info_t           info
);

  // Clamp, exact match or bracketing segment. For anything but a strict
  // interior sample the offset is zero, so the quotient later is zero too.
  always_comb begin
    logic exact;
    exact      = 1'b0;
    info.base  = irdl_pkg::DIST_PTS[irdl_pkg::TABLE_POINTS-1];
    info.delta = '0;
    info.seg   = '0;
    info.code  = irdl_pkg::RANGE_IN;
    if (sample > irdl_pkg::VOLT_PTS[0]) begin
      info.base = irdl_pkg::DIST_PTS[0];
      info.code = irdl_pkg::RANGE_NEAR;
    end else if (sample < irdl_pkg::VOLT_PTS[irdl_pkg::TABLE_POINTS-1]) begin
      info.code = irdl_pkg::RANGE_FAR;
    end else begin
      for (int i = 0; i < irdl_pkg::TABLE_POINTS; i++) begin
        if (sample == irdl_pkg::VOLT_PTS[i]) begin
          exact     = 1'b1;
          info.base = irdl_pkg::DIST_PTS[i];
        end
      end
      if (!exact) begin
        for (int i = 0; i < irdl_pkg::SEGS; i++) begin
          if (irdl_pkg::VOLT_PTS[i] > sample && sample > irdl_pkg::VOLT_PTS[i+1]) begin
            info.base  = irdl_pkg::DIST_PTS[i];
            info.delta = irdl_pkg::VOLT_PTS[i] - sample;
            info.seg   = irdl_pkg::SEG_W'(i);
          end
        end
      end
    end
  end

endmodule

// ===== hdl/irdl_div_fix.sv =====
module irdl_div_fix (
  input  logic [irdl_pkg::Q_W-1:0]   q_est,
  input  logic [irdl_pkg::NUM_W-1:0] num,
  input  logic [irdl_pkg::SEG_W-1:0] seg,
  output logic [irdl_pkg::Q_W-1:0]   q
);

  logic [irdl_pkg::DEN_W-1:0] den;
  logic [irdl_pkg::QD_W-1:0]  qd;
  logic [irdl_pkg::QD_W-1:0]  rem;

  // The reciprocal estimate is low by at most one; one compare fixes it.
  always_comb begin
    den = irdl_pkg::SEG_DEN[seg];
    qd  = irdl_pkg::QD_W'(q_est) * irdl_pkg::QD_W'(den);
    rem = irdl_pkg::QD_W'(num) - qd;
    if (rem >= irdl_pkg::QD_W'(den)) begin
      q = q_est + irdl_pkg::Q_W'(1);
    end else begin
      q = q_est;
    end
  end

endmodule

// ===== hdl/ir_distance_linearizer_unit.sv =====
// Infrared distance linearizer.
// The input channel takes one 9-bit voltage sample (10 mV units) per beat.
// The result channel returns one beat per sample: the distance in mm,
// linearly interpolated over a fixed 13-point table with the quotient
// truncated, and a range code (in table, too near, too far). Samples above
// the top voltage give the nearest distance, below the bottom the farthest.
// The pipeline has five register stages: segment lookup, offset times rise,
// times the segment reciprocal, remainder correction, and add with
// saturation; out_valid is the valid bit of the fifth stage. Throughput is
// one sample per cycle while the receiver does not stall; the three
// multipliers each sit in a stage of their own and set the depth.
// Each stage holds a valid bit. When the receiver stalls, a full stage
// holds its beat, in_ready drops once every stage is full, and nothing is
// lost or repeated. Synchronous reset clears all valid bits; nothing else
// needs clearing since the block keeps no state between samples.
module ir_distance_linearizer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [irdl_pkg::SAMPLE_W-1:0] in_sample_centivolts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [irdl_pkg::DIST_W-1:0]   out_distance_mm,
  output logic [irdl_pkg::CODE_W-1:0]   out_range_code
);

  irdl_pkg::seg_info_t seg_nxt;
  irdl_pkg::seg_info_t seg1_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [irdl_pkg::NUM_W-1:0]   num_nxt, num2_r, num3_r;
  logic [irdl_pkg::DIST_W-1:0]  base2_r, base3_r, base4_r;
  logic [irdl_pkg::SEG_W-1:0]   seg2_r, seg3_r;
  irdl_pkg::range_code_t        code2_r, code3_r, code4_r, code5_r;
  logic [irdl_pkg::PROD_W-1:0]  prod;
  logic [irdl_pkg::Q_W-1:0]     qest_nxt, qest3_r;
  logic [irdl_pkg::Q_W-1:0]     q_nxt, q4_r;
  logic [irdl_pkg::SUM_W-1:0]   sum;
  logic [irdl_pkg::DIST_W-1:0]  dist_nxt, dist5_r;

  // Stall chain: a stage loads when it is empty or its beat moves on.
  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: segment lookup.
  irdl_seg_lookup u_lookup (
    .sample (in_sample_centivolts),
    .info   (seg_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy1) seg1_r <= seg_nxt;
  end

  // Stage 2: numerator, offset times the segment's distance rise.
  assign num_nxt = irdl_pkg::NUM_W'(seg1_r.delta) *
                   irdl_pkg::NUM_W'(irdl_pkg::SEG_RISE[seg1_r.seg]);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      num2_r  <= num_nxt;
      base2_r <= seg1_r.base;
      seg2_r  <= seg1_r.seg;
      code2_r <= seg1_r.code;
    end
  end

  // Stage 3: quotient estimate by the segment reciprocal.
  assign prod     = irdl_pkg::PROD_W'(num2_r) *
                    irdl_pkg::PROD_W'(irdl_pkg::SEG_RECIP[seg2_r]);
  assign qest_nxt = prod[irdl_pkg::RECIP_SHIFT +: irdl_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      qest3_r <= qest_nxt;
      num3_r  <= num2_r;
      base3_r <= base2_r;
      seg3_r  <= seg2_r;
      code3_r <= code2_r;
    end
  end

  // Stage 4: remainder correction.
  irdl_div_fix u_fix (
    .q_est (qest3_r),
    .num   (num3_r),
    .seg   (seg3_r),
    .q     (q_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy4) begin
      q4_r    <= q_nxt;
      base4_r <= base3_r;
      code4_r <= code3_r;
    end
  end

  // Stage 5: add the base distance and saturate to the output width.
  assign sum = irdl_pkg::SUM_W'(base4_r) + irdl_pkg::SUM_W'(q4_r);
  always_comb begin
    if (sum > irdl_pkg::SUM_W'({irdl_pkg::DIST_W{1'b1}})) begin
      dist_nxt = {irdl_pkg::DIST_W{1'b1}};
    end else begin
      dist_nxt = sum[irdl_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      dist5_r <= dist_nxt;
      code5_r <= code4_r;
    end
  end

  assign out_valid       = v5_r;
  assign out_distance_mm = dist5_r;
  assign out_range_code  = code5_r;

  // A too-near result always carries the nearest distance.
  a_near_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_code == irdl_pkg::RANGE_NEAR) |->
      out_distance_mm == irdl_pkg::DIST_PTS[0])
    else $error("too-near result with wrong distance");

  // A too-far result always carries the farthest distance.
  a_far_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_code == irdl_pkg::RANGE_FAR) |->
      out_distance_mm == irdl_pkg::DIST_PTS[irdl_pkg::TABLE_POINTS-1])
    else $error("too-far result with wrong distance");

  // A stalled first stage keeps its beat.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(seg1_r)))
    else $error("stage one beat changed during a stall");

  // The corrected quotient never exceeds its numerator.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> q_nxt <= num3_r)
    else $error("quotient larger than numerator");

endmodule
